// ----- rtl/frwa_pkg.sv -----
// ----------------------------------------------------------------------------
// frwa_pkg
// Shared types and constants for the frame rate window average block.
// ----------------------------------------------------------------------------
package frwa_pkg;

	localparam int TIME_W    = 32;
	localparam int ELAPSED_W = 40;
	localparam int COUNT_W   = 16;

	localparam logic [TIME_W-1:0]  TPS_RESET = 32'd1000000;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_UPDATE,
		ST_DIVIDE,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic close;
		logic update;
		logic div_step;
		logic set_mean;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic reach;
		logic div_done;
	} status_t;

endpackage

// ----- rtl/frwa_in_if.sv -----
// ----------------------------------------------------------------------------
// frwa_in_if
// Frame event channel: valid, ready and the finished frame's duration.
// ----------------------------------------------------------------------------
interface frwa_in_if;
	logic                        valid;
	logic                        ready;
	logic [frwa_pkg::TIME_W-1:0] frame_time;

	modport source (output valid, output frame_time, input ready);
	modport sink (input valid, input frame_time, output ready);
endinterface

// ----- rtl/frwa_out_if.sv -----
// ----------------------------------------------------------------------------
// frwa_out_if
// Rate report channel: valid, ready and the per-frame counts and average.
// ----------------------------------------------------------------------------
interface frwa_out_if;
	logic                         valid;
	logic                         ready;
	logic [frwa_pkg::COUNT_W-1:0] frames_this_second;
	logic [frwa_pkg::COUNT_W-1:0] frames_last_second;
	logic [frwa_pkg::COUNT_W-1:0] average_rate;
	logic                         second_closed;

	modport source (output valid, output frames_this_second, output frames_last_second,
		output average_rate, output second_closed, input ready);
	modport sink (input valid, input frames_this_second, input frames_last_second,
		input average_rate, input second_closed, output ready);
endinterface

// ----- rtl/frame_rate_window_average_top.sv -----
// ----------------------------------------------------------------------------
// frame_rate_window_average_top
// Frame rate counter with a moving average over recent seconds.
// ----------------------------------------------------------------------------
// One word on frame_in carries the duration of a finished frame in ticks;
// each word gives exactly one word on rate_out with the open-second count,
// the last closed second's count, the mean over the history ring and a flag
// that this frame closed a second. ticks_per_second is written through
// cfg_wr_en / cfg_wr_data; the user must write it only while no frame is
// in flight, as the block does not enforce this. A frame that closes no
// second goes from the check step to the output register; a closing frame
// first passes the ring update and the bit-serial divider, which forms the
// mean of the window total over the filled entry count.
// Throughput: one frame at a time; frame_in.ready is high only while the
// sequencer is idle, so the next frame is taken in the cycle after the
// previous result reaches the output register.
// A result waiting on a stalled receiver does not block the next frame; that
// frame is processed and holds in its last step until the output register
// frees up. Reset clears the frame counters, the ring pointer and the mean;
// ring entries are only used once written, so they need no clearing.
// ----------------------------------------------------------------------------
module frame_rate_window_average_top #(
	parameter int HISTORY_DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [frwa_pkg::TIME_W-1:0] cfg_wr_data,
	frwa_in_if.sink                     frame_in,
	frwa_out_if.source                  rate_out
);

	frwa_pkg::cmd_t    cmd;
	frwa_pkg::status_t status;

	// sequencer
	frwa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (frame_in.valid),
		.in_ready  (frame_in.ready),
		.out_valid (rate_out.valid),
		.out_ready (rate_out.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// counters, ring, divider and output register
	frwa_datapath #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data),
		.frame_time         (frame_in.frame_time),
		.cmd                (cmd),
		.status             (status),
		.frames_this_second (rate_out.frames_this_second),
		.frames_last_second (rate_out.frames_last_second),
		.average_rate       (rate_out.average_rate),
		.second_closed      (rate_out.second_closed)
	);

endmodule

// ----- rtl/frwa_datapath.sv -----
// ----------------------------------------------------------------------------
// frwa_datapath
// Elapsed time accumulator, frame counter, history ring with running window
// total, bit-serial divider for the mean, and the output word register.
// ----------------------------------------------------------------------------
module frwa_datapath #(
	parameter int HISTORY_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [frwa_pkg::TIME_W-1:0]   cfg_wr_data,
	input  logic [frwa_pkg::TIME_W-1:0]   frame_time,
	input  frwa_pkg::cmd_t                cmd,
	output frwa_pkg::status_t             status,
	output logic [frwa_pkg::COUNT_W-1:0]  frames_this_second,
	output logic [frwa_pkg::COUNT_W-1:0]  frames_last_second,
	output logic [frwa_pkg::COUNT_W-1:0]  average_rate,
	output logic                          second_closed
);

	localparam int EW      = frwa_pkg::ELAPSED_W;
	localparam int CW      = frwa_pkg::COUNT_W;
	localparam int PW      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int FW      = $clog2(HISTORY_DEPTH + 1);
	localparam int TOTAL_W = CW + $clog2(HISTORY_DEPTH);
	localparam int NW      = $clog2(TOTAL_W + 1);

	logic [frwa_pkg::TIME_W-1:0] tps_q;
	logic [EW-1:0]               elapsed_q;
	logic [CW-1:0]               counter_q;
	logic [CW-1:0]               last_q;
	logic [CW-1:0]               mean_q;
	logic [PW-1:0]               pos_q;
	logic                        wrapped_q;
	logic [TOTAL_W-1:0]          total_q;
	logic                        closed_q;
	logic [CW-1:0]               old_q;
	logic [CW-1:0]               ring_mem [HISTORY_DEPTH];

	logic [TOTAL_W-1:0]          quo_q;
	logic [FW-1:0]               rem_q;
	logic [FW-1:0]               div_q;
	logic [NW-1:0]               cnt_q;

	logic [EW:0]                 sum_wide;
	logic [EW-1:0]               elapsed_sat;
	logic [EW-1:0]               tps_ext;
	logic [TOTAL_W-1:0]          total_next;
	logic [FW-1:0]               filled;
	logic [FW:0]                 trial;
	logic                        trial_ge;

	// saturating accumulate and one-second compare
	assign sum_wide    = {1'b0, elapsed_q} + (EW + 1)'(frame_time);
	assign elapsed_sat = sum_wide[EW] ? {EW{1'b1}} : sum_wide[EW-1:0];
	assign tps_ext     = EW'(tps_q);

	// running window total: the new count replaces the entry it overwrites
	assign total_next = total_q + TOTAL_W'(last_q) - (wrapped_q ? TOTAL_W'(old_q) : '0);
	assign filled     = wrapped_q ? FW'(HISTORY_DEPTH) : FW'(pos_q) + FW'(1);

	// restoring divide step
	assign trial    = {rem_q, quo_q[TOTAL_W-1]};
	assign trial_ge = trial >= {1'b0, div_q};

	assign status.reach    = elapsed_q >= tps_ext;
	assign status.div_done = (cnt_q == '0);

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q     <= frwa_pkg::TPS_RESET;
			elapsed_q <= '0;
			counter_q <= '0;
			last_q    <= '0;
			mean_q    <= '0;
			pos_q     <= '0;
			wrapped_q <= 1'b0;
			total_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				tps_q <= cfg_wr_data;
			end
			if (cmd.accept) begin
				elapsed_q <= elapsed_sat;
				if (counter_q != frwa_pkg::COUNT_MAX) begin
					counter_q <= counter_q + CW'(1);
				end
			end
			if (cmd.close) begin
				elapsed_q <= elapsed_q - tps_ext;
				last_q    <= counter_q;
				counter_q <= '0;
			end
			if (cmd.update) begin
				total_q <= total_next;
				if (pos_q == PW'(HISTORY_DEPTH - 1)) begin
					pos_q     <= '0;
					wrapped_q <= 1'b1;
				end else begin
					pos_q <= pos_q + PW'(1);
				end
			end
			if (cmd.set_mean) begin
				mean_q <= quo_q[CW-1:0];
			end
		end
	end

	// history ring
	always_ff @(posedge clk) begin
		if (cmd.close) begin
			old_q <= ring_mem[pos_q];
		end
		if (cmd.update) begin
			ring_mem[pos_q] <= last_q;
		end
	end

	// divider, close flag and output word
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			closed_q <= 1'b0;
		end
		if (cmd.close) begin
			closed_q <= 1'b1;
		end
		if (cmd.update) begin
			quo_q <= total_next;
			rem_q <= '0;
			div_q <= filled;
			cnt_q <= NW'(TOTAL_W);
		end
		if (cmd.div_step) begin
			quo_q <= {quo_q[TOTAL_W-2:0], trial_ge};
			rem_q <= trial_ge ? FW'(trial - {1'b0, div_q}) : FW'(trial);
			cnt_q <= cnt_q - NW'(1);
		end
		if (cmd.load_out) begin
			frames_this_second <= counter_q;
			frames_last_second <= last_q;
			average_rate       <= mean_q;
			second_closed      <= closed_q;
		end
	end

endmodule

// ----- rtl/frwa_ctrl.sv -----
// ----------------------------------------------------------------------------
// frwa_ctrl
// Sequencer for one frame event: accumulate, check and, when a second closes,
// ring update and divide, then hand the word to the output register.
// ----------------------------------------------------------------------------
module frwa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  frwa_pkg::status_t status,
	output frwa_pkg::cmd_t    cmd
);

	frwa_pkg::state_t state_q;
	frwa_pkg::state_t state_d;
	logic             out_valid_q;

	assign out_valid = out_valid_q;

	// state register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= frwa_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			frwa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = frwa_pkg::ST_CHECK;
				end
			end
			frwa_pkg::ST_CHECK: begin
				if (status.reach) begin
					cmd.close = 1'b1;
					state_d   = frwa_pkg::ST_UPDATE;
				end else begin
					state_d = frwa_pkg::ST_DONE;
				end
			end
			frwa_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = frwa_pkg::ST_DIVIDE;
			end
			frwa_pkg::ST_DIVIDE: begin
				if (status.div_done) begin
					cmd.set_mean = 1'b1;
					state_d      = frwa_pkg::ST_DONE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			frwa_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = frwa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = frwa_pkg::ST_IDLE;
			end
		endcase
	end

	// checks
	a_close_then_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.close |=> state_q == frwa_pkg::ST_UPDATE)
		else $error("close not followed by ring update");

	a_step_only_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !status.div_done)
		else $error("divide step after last iteration");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("output word loaded without valid");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("pending output word overwritten");

endmodule
